[src/aufp_pkg.sv]
`default_nettype none

package aufp_pkg;

	// bit widths of the stream elements
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CARRY_W  = 7;
	localparam int unsigned HDR_W    = 23;

	// frame header: channel code 1, zero fields, not-compressed flag set
	localparam logic [HDR_W-1:0] HDR_VALUE = 23'h100001;

	// widest packed word: header, both samples and the flush position
	localparam int unsigned WORD_W = HDR_W + 2 * SAMPLE_W + 1;

	// byte counts per queued word
	localparam int unsigned NBYTES_W = 3;
	localparam logic [NBYTES_W-1:0] NBYTES_MID        = 3'd4;
	localparam logic [NBYTES_W-1:0] NBYTES_MID_LAST   = 3'd5;
	localparam logic [NBYTES_W-1:0] NBYTES_FIRST      = 3'd6;
	localparam logic [NBYTES_W-1:0] NBYTES_FIRST_LAST = 3'd7;

	// default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// one classified pair, left aligned, ready for serialisation
	typedef struct packed {
		logic [WORD_W-1:0]   bits;
		logic [NBYTES_W-1:0] nbytes;
		logic                last;
	} aufp_entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} aufp_qstat_t;

endpackage

`default_nettype wire

[src/aufp_front.sv]
`default_nettype none

module aufp_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [aufp_pkg::SAMPLE_W-1:0] left_sample,
	input  wire logic signed [aufp_pkg::SAMPLE_W-1:0] right_sample,
	input  wire logic                                last_sample,
	input  wire aufp_pkg::aufp_qstat_t               qstat,
	output logic                                     push,
	output aufp_pkg::aufp_entry_t                    push_entry
);
	import aufp_pkg::*;

	logic [CARRY_W-1:0] carry_q;
	logic               started_q;
	logic               accept;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !qstat.full;
	assign push     = accept;

	// frame state: leftover bits and header-sent flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q   <= '0;
			started_q <= 1'b0;
		end else if (accept) begin
			if (last_sample) begin
				carry_q   <= '0;
				started_q <= 1'b0;
			end else begin
				carry_q   <= right_sample[CARRY_W-1:0];
				started_q <= 1'b1;
			end
		end
	end

	// build left-aligned word with byte count for the back end
	always_comb begin
		push_entry.last = last_sample;
		if (started_q) begin
			push_entry.bits = {carry_q, left_sample, right_sample, 1'b0,
				{(WORD_W - CARRY_W - 2 * SAMPLE_W - 1){1'b0}}};
			push_entry.nbytes = last_sample ? NBYTES_MID_LAST : NBYTES_MID;
		end else begin
			push_entry.bits   = {HDR_VALUE, left_sample, right_sample, 1'b0};
			push_entry.nbytes = last_sample ? NBYTES_FIRST_LAST : NBYTES_FIRST;
		end
	end

endmodule

`default_nettype wire

[src/aufp_queue.sv]
`default_nettype none

module aufp_queue #(
	parameter int unsigned DEPTH = aufp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire aufp_pkg::aufp_entry_t push_entry,
	input  wire logic                  pop,
	output aufp_pkg::aufp_entry_t      head,
	output aufp_pkg::aufp_qstat_t      qstat
);
	import aufp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	aufp_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_FULL);
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// no overflow, no underflow, count in range
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> !pop)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count out of range");

endmodule

`default_nettype wire

[src/aufp_back.sv]
`default_nettype none

module aufp_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire aufp_pkg::aufp_entry_t      head,
	input  wire aufp_pkg::aufp_qstat_t      qstat,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [aufp_pkg::BYTE_W-1:0]     out_byte,
	output logic                            last_byte
);
	import aufp_pkg::*;

	logic [WORD_W-1:0]   shift_q;
	logic [NBYTES_W-1:0] remaining_q;
	logic                last_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                last_byte_q;
	logic                adv;
	logic                drained;

	// a byte moves into the output register when it is free or being taken
	assign adv     = (remaining_q != '0) && (!out_valid_q || !out_stall);
	assign drained = (remaining_q == '0) || ((remaining_q == NBYTES_W'(1)) && adv);
	assign pop     = drained && !qstat.empty;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_byte_q;

	// word shifter and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			last_q      <= 1'b0;
		end else if (pop) begin
			remaining_q <= head.nbytes;
			last_q      <= head.last;
		end else if (adv) begin
			remaining_q <= remaining_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q <= head.bits;
		end else if (adv) begin
			shift_q <= {shift_q[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q  <= shift_q[WORD_W-1:WORD_W-BYTE_W];
			last_byte_q <= last_q && (remaining_q == NBYTES_W'(1));
		end
	end

	// loaded words carry four to seven bytes
	a_nbytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (head.nbytes == NBYTES_MID) || (head.nbytes == NBYTES_MID_LAST) ||
			(head.nbytes == NBYTES_FIRST) || (head.nbytes == NBYTES_FIRST_LAST))
		else $error("queued word has a bad byte count");
	// final byte of a last word is flagged
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_q && (remaining_q == NBYTES_W'(1)) |=> last_byte_q && out_valid_q)
		else $error("final byte not flagged");
	// earlier bytes are never flagged
	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (remaining_q > NBYTES_W'(1)) |=> !last_byte_q)
		else $error("byte flagged as last too early");

endmodule

`default_nettype wire

[src/alac_uncompressed_frame_packer_unit.sv]
`default_nettype none

// Packs stereo 16-bit sample pairs into an uncompressed ALAC-style frame, one
// byte per transfer, most significant bit first. The first pair of a frame is
// preceded by the 23-bit header; the pair flagged last_sample ends with a
// zero-filled flush byte marked last_byte. A pair mid-frame gives 4 bytes, a
// first pair 6, and a last pair one more; the byte-wide output register sets
// the sustained rate. The front end takes a pair in any cycle while the queue
// (QUEUE_DEPTH words) has room, so input transfers run back to back until the
// queue fills; an accepted pair passes through the queue, the word shifter and
// the output register before its first byte appears.

module alac_uncompressed_frame_packer_unit #(
	parameter int unsigned QUEUE_DEPTH = aufp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [aufp_pkg::SAMPLE_W-1:0] left_sample,
	input  wire logic signed [aufp_pkg::SAMPLE_W-1:0] right_sample,
	input  wire logic                                 last_sample,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [aufp_pkg::BYTE_W-1:0]               out_byte,
	output logic                                      last_byte
);
	import aufp_pkg::*;

	aufp_entry_t push_entry;
	aufp_entry_t head;
	aufp_qstat_t qstat;
	logic        push;
	logic        pop;

	// classify pairs and build packed words
	aufp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_sample  (last_sample),
		.qstat        (qstat),
		.push         (push),
		.push_entry   (push_entry)
	);

	// decoupling queue
	aufp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// serialise words into bytes
	aufp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import aufp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_PAIRS = 212;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned N_DIRECTED   = 18;
	localparam int unsigned MAX_BYTES    = 7;

	// one frame byte as the output side presents it
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
	} frame_byte_t;

	// one sample pair; where fixed is set, bytes holds the whole frame, first byte on top
	typedef struct packed {
		logic [SAMPLE_W-1:0]         left;
		logic [SAMPLE_W-1:0]         right;
		logic                        last;
		logic                        fixed;
		logic [MAX_BYTES*BYTE_W-1:0] bytes;
	} pair_row_t;

	// receiver back-pressure styles
	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_SCATTER,
		FLOW_RUNS
	} flow_mode_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] left_sample  = '0;
	logic [SAMPLE_W-1:0] right_sample = '0;
	logic                last_sample  = 1'b0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [BYTE_W-1:0]   out_byte;
	logic                last_byte;

	// packer state as predicted
	logic [CARRY_W-1:0]  carry_q    = '0;
	logic                frame_open = 1'b0;
	frame_byte_t         frame_bytes [MAX_BYTES];
	frame_byte_t         expected_bytes [$];

	int                  errors        = 0;
	int                  bytes_checked = 0;
	int                  pairs_sent    = 0;
	int                  frames_sent   = 0;
	int                  burst_left    = 0;
	int                  cycle_count   = 0;
	int                  stall_run     = 0;
	flow_mode_t          flow_mode     = FLOW_FREE;

	// directed pairs: single-pair frames, mostly at the extremes, then multi-pair frames and more single-pair frames
	pair_row_t directed_rows [N_DIRECTED] = '{
		{16'h0000, 16'h0000, 1'b1, 1'b1, 56'h20_00_02_00_00_00_00},
		{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 56'h20_00_03_FF_FF_FF_FE},
		{16'h8000, 16'h7FFF, 1'b1, 1'b1, 56'h20_00_03_00_00_FF_FE},
		{16'h7FFF, 16'h8000, 1'b1, 1'b1, 56'h20_00_02_FF_FF_00_00},
		{16'h5555, 16'hAAAA, 1'b1, 1'b0, 56'h0},
		{16'h1234, 16'h5678, 1'b0, 1'b0, 56'h0},
		{16'hFFFF, 16'h0000, 1'b0, 1'b0, 56'h0},
		{16'h0000, 16'hFFFF, 1'b0, 1'b0, 56'h0},
		{16'h8000, 16'h8000, 1'b0, 1'b0, 56'h0},
		{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 56'h0},
		{16'h5555, 16'hAAAA, 1'b0, 1'b0, 56'h0},
		{16'hAAAA, 16'h5555, 1'b1, 1'b0, 56'h0},
		{16'h0001, 16'hFFFE, 1'b0, 1'b0, 56'h0},
		{16'h8001, 16'h7FFE, 1'b1, 1'b0, 56'h0},
		{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 56'h0},
		{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 56'h0},
		{16'h0000, 16'h0000, 1'b1, 1'b1, 56'h20_00_02_00_00_00_00},
		{16'hC3A5, 16'h5A3C, 1'b1, 1'b0, 56'h0}
	};

	alac_uncompressed_frame_packer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_byte    (last_byte)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// pack one pair into frame_bytes, header first on a new frame, flush on the last pair
	function automatic int pack_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
			input logic lst);
		logic [63:0] acc;
		int          nbits;
		int          n;
		n = 0;
		if (frame_open) begin
			acc   = {57'd0, carry_q};
			nbits = CARRY_W;
		end else begin
			acc   = {41'd0, HDR_VALUE};
			nbits = HDR_W;
		end
		acc   = {acc[31:0], l, r};
		nbits = nbits + 2 * SAMPLE_W;
		while (nbits >= BYTE_W + CARRY_W) begin
			frame_bytes[n] = {acc[nbits-1 -: BYTE_W], 1'b0};
			n = n + 1;
			nbits = nbits - BYTE_W;
		end
		// seven bits remain: flush them zero-filled or keep them for the next pair
		if (lst) begin
			frame_bytes[n] = {acc[CARRY_W-1:0], 1'b0, 1'b1};
			n = n + 1;
			carry_q    = '0;
			frame_open = 1'b0;
		end else begin
			carry_q    = acc[CARRY_W-1:0];
			frame_open = 1'b1;
		end
		return n;
	endfunction

	// random sample leaning towards the extremes
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 11))
			0: v[SAMPLE_W-1:0] = 16'h8000;
			1: v[SAMPLE_W-1:0] = 16'h7FFF;
			2: v[SAMPLE_W-1:0] = 16'h0000;
			3: v[SAMPLE_W-1:0] = 16'hFFFF;
			default: ;
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	// offer one pair, wait for its transfer, queue its bytes, then maybe pause
	task automatic send_pair(input pair_row_t row);
		int n;
		int gap;
		int i;
		left_sample  <= row.left;
		right_sample <= row.right;
		last_sample  <= row.last;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n = pack_pair(row.left, row.right, row.last);
		if (row.fixed) begin
			for (i = 0; i < MAX_BYTES; i++) begin
				expected_bytes.push_back({row.bytes[(MAX_BYTES-1-i)*BYTE_W +: BYTE_W],
					row.last && (i == MAX_BYTES - 1)});
			end
		end else begin
			for (i = 0; i < n; i++) begin
				expected_bytes.push_back(frame_bytes[i]);
			end
		end
		pairs_sent = pairs_sent + 1;
		if (row.last) begin
			frames_sent = frames_sent + 1;
		end
		// bursts of random length with random gaps, some with no gap at all
		if (burst_left > 0) begin
			burst_left = burst_left - 1;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// receiver back-pressure with a randomly re-chosen style
	always @(posedge clk) begin
		if (cycle_count % 64 == 0) begin
			flow_mode <= flow_mode_t'($urandom_range(0, 2));
		end
		case (flow_mode)
			FLOW_FREE: out_stall <= 1'b0;
			FLOW_SCATTER: out_stall <= ($urandom_range(0, 3) == 0);
			FLOW_RUNS: begin
				if (stall_run == 0) begin
					out_stall <= ~out_stall;
					stall_run <= $urandom_range(1, 8);
				end else begin
					stall_run <= stall_run - 1;
				end
			end
			default: out_stall <= 1'b0;
		endcase
	end

	// compare each output transfer with the oldest queued byte
	always @(posedge clk) begin
		frame_byte_t exp_b;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual %02h last %0b",
					$time, out_byte, last_byte);
				errors = errors + 1;
			end else begin
				exp_b = expected_bytes.pop_front();
				if (out_byte !== exp_b.value) begin
					$display("%0t: out_byte mismatch: expected %02h, actual %02h",
						$time, exp_b.value, out_byte);
					errors = errors + 1;
				end
				if (last_byte !== exp_b.last) begin
					$display("%0t: last_byte mismatch: expected %0b, actual %0b",
						$time, exp_b.last, last_byte);
					errors = errors + 1;
				end
			end
			bytes_checked = bytes_checked + 1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d bytes outstanding", $time, expected_bytes.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// stimulus
	initial begin
		pair_row_t row;
		int        frame_len;
		int        longest_frame;
		int        random_pairs;
		int        i;
		int        k;
		longest_frame = 0;
		random_pairs  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			send_pair(directed_rows[i]);
		end

		// random frames, mostly short, now and then a long one
		while (random_pairs < RANDOM_PAIRS) begin
			frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
			// the final frame is cut to the remaining pair budget
			if (frame_len > int'(RANDOM_PAIRS) - random_pairs) begin
				frame_len = int'(RANDOM_PAIRS) - random_pairs;
			end
			if (frame_len > longest_frame) begin
				longest_frame = frame_len;
			end
			for (k = 0; k < frame_len; k++) begin
				row       = '0;
				row.left  = pick_sample();
				row.right = pick_sample();
				row.last  = (k == frame_len - 1);
				send_pair(row);
				random_pairs = random_pairs + 1;
			end
		end
		in_valid <= 1'b0;

		// drain
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("packed %0d pairs in %0d frames (%0d directed pairs), longest random frame %0d",
			pairs_sent, frames_sent, N_DIRECTED, longest_frame);
		$display("%0d frame bytes compared, %0d mismatches", bytes_checked, errors);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
